// File: rtl/mbrc_pkg.sv
// Shared types, constants and arithmetic helpers for the bit reservoir control block.
`default_nettype none

package mbrc_pkg;

  // Event kinds carried in the input tuser
  typedef enum logic [1:0] {
    ACT_FRAME_BEGIN = 2'd0,
    ACT_GRAN_QUERY  = 2'd1,
    ACT_GRAN_ADJUST = 2'd2,
    ACT_FRAME_END   = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MPEG_ONE   = 2'd0;
  localparam logic [1:0] CFG_GRANULES   = 2'd1;
  localparam logic [1:0] CFG_CHANNELS   = 2'd2;

  // Frame and reservoir limits in bits
  localparam logic [14:0] MAX_FRAME_BITS = 15'(8 * 2047);
  localparam logic [11:0] CAP_MPEG1      = 12'(8 * 511);
  localparam logic [11:0] CAP_MPEG2      = 12'(8 * 255);

  // Output item layout, lowest bit first
  localparam int BUDGET_LSB = 0;
  localparam int TARGET_LSB = 16;
  localparam int EXTRA_LSB  = 32;
  localparam int STUFF_LSB  = 44;
  localparam int RESV_LSB   = 61;

  // Floor divide by 10 through a scaled reciprocal, exact below 2^18
  function automatic logic [14:0] div10(input logic [17:0] x);
    logic [35:0] p;
    p = 36'(x) * 36'd209716;
    return p[35:21];
  endfunction

  // Floor divide by 3 through a scaled reciprocal, exact below 2^17
  function automatic logic [12:0] div3(input logic [13:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'd43691;
    return p[29:17];
  endfunction

endpackage

`default_nettype wire

// File: rtl/mp3_bit_reservoir_control.sv
// Top level of the Layer III bit reservoir control block.
//
//  channel | direction | signals                       | content
//  --------+-----------+-------------------------------+--------------------------------
//  s_*     | in        | s_tvalid s_tready s_tdata s_tuser | one event item
//  m_*     | out       | m_tvalid m_tready m_tdata     | one result item per event
//  cfg_*   | in        | cfg_we cfg_index cfg_data     | register writes, no read-back
//
// Each event is worked out in the cycle it is accepted; its result shows in the output
// register in the next cycle, so an item can enter every cycle while no result is stalled.
// The reservoir size and limit update at the accept edge, so the next item sees them.
// The input stalls only while a result waits and m_tready is low.
// Synchronous active-high reset clears the reservoir, the limit and the output valid.
`default_nettype none

module mp3_bit_reservoir_control (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // granule_mean[13:0], frame_length[28:14], used_bits[40:29]
  input  wire logic [1:0]  s_tuser,   // action[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // frame_budget[15:0], target_bits[31:16],
                                      // borrow_bits[43:32], stuffing_bits[60:44],
                                      // reservoir_now[78:61]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [1:0]  cfg_data
);
  import mbrc_pkg::*;

  // Configuration registers
  logic       mpeg_one;
  logic [1:0] granules_per_frame;
  logic [1:0] channel_count;

  // Reservoir state
  logic signed [17:0] reservoir_size;
  logic [11:0]        reservoir_limit;
  logic signed [17:0] reservoir_size_next;
  logic [11:0]        reservoir_limit_next;

  // Result fields before the output register
  logic [15:0]        budget_next;
  logic [15:0]        target_next;
  logic [11:0]        extra_next;
  logic signed [16:0] stuff_next;

  // Input fields
  action_t     action;
  logic [13:0] granule_mean;
  logic [14:0] frame_length;
  logic [11:0] used_bits;

  logic accept;

  assign action       = action_t'(s_tuser);
  assign granule_mean = s_tdata[13:0];
  assign frame_length = s_tdata[28:14];
  assign used_bits    = s_tdata[40:29];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Frame begin terms
  logic [13:0]        lim_raw;
  logic [11:0]        cap;
  logic [11:0]        limit_new;
  logic signed [18:0] smaller;
  logic [15:0]        mean_gran;
  logic signed [19:0] budget_sum;

  // Granule query terms
  logic [15:0]        lim9;
  logic [14:0]        lim6;
  logic [17:0]        mean9;
  logic [14:0]        thr;
  logic [14:0]        cap6;
  logic [14:0]        target_low;
  logic               over_thr;
  logic signed [18:0] excess;
  logic [18:0]        target_sum;
  logic signed [18:0] min_sc;
  logic signed [19:0] extra_sum;

  // Granule adjust terms
  logic [13:0] share;

  // Frame end terms
  logic signed [17:0] size_rnd;
  logic signed [3:0]  smod;
  logic signed [18:0] size_trunc;
  logic signed [19:0] over;
  logic signed [18:0] drain;

  always_comb begin
    // Frame begin: limit from frame length, budget from mean and reservoir
    cap       = mpeg_one ? CAP_MPEG1 : CAP_MPEG2;
    lim_raw   = 14'(MAX_FRAME_BITS - frame_length);
    if (frame_length > MAX_FRAME_BITS) begin
      limit_new = '0;
    end else if (lim_raw > {2'b00, cap}) begin
      limit_new = cap;
    end else begin
      limit_new = lim_raw[11:0];
    end
    if (19'(reservoir_size) < $signed({7'd0, limit_new})) begin
      smaller = 19'(reservoir_size);
    end else begin
      smaller = $signed({7'd0, limit_new});
    end
    mean_gran  = 16'(granule_mean) * 16'(granules_per_frame);
    budget_sum = $signed({4'd0, mean_gran}) + 20'(smaller);

    // Granule query: 90 percent threshold and 60 percent borrow cap
    lim9       = {1'b0, reservoir_limit, 3'b000} + 16'(reservoir_limit);
    lim6       = {1'b0, reservoir_limit, 2'b00} + {2'b00, reservoir_limit, 1'b0};
    mean9      = {1'b0, granule_mean, 3'b000} + 18'(granule_mean);
    thr        = div10(18'(lim9));
    cap6       = div10(18'(lim6));
    target_low = div10(mean9);
    over_thr   = 19'(reservoir_size) > $signed({4'd0, thr});
    excess     = over_thr ? (19'(reservoir_size) - $signed({4'd0, thr})) : '0;
    target_sum = 19'(granule_mean) + 19'(excess);
    if (19'(reservoir_size) < $signed({4'd0, cap6})) begin
      min_sc = 19'(reservoir_size);
    end else begin
      min_sc = $signed({4'd0, cap6});
    end
    extra_sum = 20'(min_sc) - 20'(excess);

    // Granule adjust: mean share of one channel
    case (channel_count)
      2'd2:    share = {1'b0, granule_mean[13:1]};
      2'd3:    share = {1'b0, div3(granule_mean)};
      default: share = granule_mean;
    endcase

    // Frame end: odd stereo rounding, truncating remainder, overflow drain
    if (channel_count == 2'd2 && granule_mean[0]) begin
      size_rnd = reservoir_size + 18'sd1;
    end else begin
      size_rnd = reservoir_size;
    end
    if (size_rnd[17] && size_rnd[2:0] != 3'd0) begin
      smod = {1'b1, size_rnd[2:0]};
    end else begin
      smod = {1'b0, size_rnd[2:0]};
    end
    size_trunc = 19'(size_rnd) - 19'(smod);
    over       = 20'(size_trunc) - $signed({8'd0, reservoir_limit});
    drain      = 19'(size_rnd) - $signed({7'd0, reservoir_limit});

    // Defaults: unused result fields are zero, state holds
    budget_next          = '0;
    target_next          = '0;
    extra_next           = '0;
    stuff_next           = '0;
    reservoir_size_next  = reservoir_size;
    reservoir_limit_next = reservoir_limit;

    unique case (action)
      ACT_FRAME_BEGIN: begin
        reservoir_limit_next = limit_new;
        if (budget_sum < 0) begin
          budget_next = '0;
        end else if (budget_sum > 20'sd65535) begin
          budget_next = 16'hFFFF;
        end else begin
          budget_next = budget_sum[15:0];
        end
      end
      ACT_GRAN_QUERY: begin
        if (over_thr) begin
          target_next = (target_sum > 19'd65535) ? 16'hFFFF : target_sum[15:0];
        end else begin
          target_next = 16'(target_low);
        end
        extra_next = (extra_sum < 0) ? 12'd0 : extra_sum[11:0];
      end
      ACT_GRAN_ADJUST: begin
        reservoir_size_next = reservoir_size + $signed(18'(share)) - $signed(18'(used_bits));
      end
      ACT_FRAME_END: begin
        if (over > 0) begin
          reservoir_size_next = $signed({6'd0, reservoir_limit});
          stuff_next = (drain > 19'sd65535) ? 17'sd65535 : drain[16:0];
        end else begin
          reservoir_size_next = size_rnd - 18'(smod);
          stuff_next          = 17'(smod);
        end
      end
    endcase
  end

  // Configuration writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      mpeg_one           <= 1'b1;
      granules_per_frame <= 2'd2;
      channel_count      <= 2'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MPEG_ONE: mpeg_one           <= cfg_data[0];
        CFG_GRANULES: granules_per_frame <= cfg_data;
        CFG_CHANNELS: channel_count      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the reservoir state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      reservoir_size  <= '0;
      reservoir_limit <= '0;
    end else if (accept) begin
      reservoir_size  <= reservoir_size_next;
      reservoir_limit <= reservoir_limit_next;
    end
  end

  // Output valid: set on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // Output payload: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, reservoir_size_next, stuff_next, extra_next, target_next, budget_next};
    end
  end

endmodule

`default_nettype wire

// File: rtl/mbrc_checker.sv
// Port-level checker for the bit reservoir control block, bound to its top level.
`default_nettype none

module mbrc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata
);
  import mbrc_pkg::*;

  logic [15:0] budget;
  logic [15:0] target;
  logic [11:0] extra;
  logic [16:0] stuff;

  assign budget = m_tdata[BUDGET_LSB +: 16];
  assign target = m_tdata[TARGET_LSB +: 16];
  assign extra  = m_tdata[EXTRA_LSB +: 12];
  assign stuff  = m_tdata[STUFF_LSB +: 17];

  // A waiting result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Input is taken whenever the output slot is free or draining
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output slot");

  // Every accepted item gives a result in the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item gave no result");

  // A nonzero budget only comes from frame begin, where the target, borrow and stuffing fields are zero
  a_budget_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && budget != 16'd0 |-> target == 16'd0 && extra == 12'd0 && stuff == 17'd0)
    else $error("frame budget mixed with other event fields");

endmodule

bind mp3_bit_reservoir_control mbrc_checker u_mbrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
